// File: src/mhbv_pkg.sv
// Shared types and constants for the mail header block validator.
`timescale 1ns / 1ps

package mhbv_pkg;

  localparam int MHBV_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [2:0] CLS_HEADER = 3'd0;
  localparam logic [2:0] CLS_CONT   = 3'd1;
  localparam logic [2:0] CLS_BLANK  = 3'd2;
  localparam logic [2:0] CLS_STATUS = 3'd3;
  localparam logic [2:0] CLS_TERM   = 3'd4;
  localparam logic [2:0] CLS_REJECT = 3'd5;
  localparam logic [2:0] CLS_NONE   = 3'd6;

  localparam logic [2:0] LEN_MAX = 3'd7;

  typedef enum logic [1:0] {
    FIN_RUNNING    = 2'd0,
    FIN_TERMINATED = 2'd1,
    FIN_ERROR      = 2'd2
  } fin_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [2:0] line_class;
    logic       block_end;
    logic       block_status;
  } res_t;

  typedef struct packed {
    logic [2:0] len;
    logic       match_status;
    logic       first_dot;
    logic       first_blank;
    logic       colon_found;
    logic       name_invalid;
  } line_t;

  typedef struct packed {
    line_t      line_nxt;
    logic       header_nxt;
    fin_t       fin_nxt;
    logic [1:0] push_n;
    res_t       res0;
    res_t       res1;
  } step_t;

  localparam line_t LINE_CLEAR = '{len: 3'd0, match_status: 1'b1, first_dot: 1'b0,
                                   first_blank: 1'b0, colon_found: 1'b0,
                                   name_invalid: 1'b0};

  function automatic logic [7:0] status_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_PLUS;
      2'd1:    c = CH_O;
      default: c = CH_K;
    endcase
    return c;
  endfunction

endpackage

// File: src/mhbv_line_unit.sv
// Per-byte line tracking and line classification for one accepted byte.
`timescale 1ns / 1ps

module mhbv_line_unit (
  input  mhbv_pkg::line_t line_q,
  input  logic            header_q,
  input  mhbv_pkg::fin_t  fin_q,
  input  mhbv_pkg::in_t   item,
  output mhbv_pkg::step_t step
);
  import mhbv_pkg::*;

  typedef struct packed {
    logic [2:0] cls;
    logic       hdr;
    fin_t       fin;
  } cls_out_t;

  function automatic cls_out_t classify(input line_t l, input logic hdr, input fin_t fin);
    cls_out_t o;
    o.hdr = hdr;
    o.fin = fin;
    if (l.match_status && l.len == 3'd3 && !hdr) begin
      o.cls = CLS_STATUS;
    end else if (l.first_dot && l.len == 3'd1) begin
      o.cls = CLS_TERM;
      o.fin = FIN_TERMINATED;
    end else if (l.len == 3'd0) begin
      o.cls = CLS_BLANK;
    end else if (l.first_blank) begin
      if (!hdr) begin
        o.cls = CLS_REJECT;
        o.fin = FIN_ERROR;
      end else begin
        o.cls = CLS_CONT;
      end
    end else if (l.colon_found && !l.name_invalid) begin
      o.cls = CLS_HEADER;
      o.hdr = 1'b1;
    end else begin
      o.cls = CLS_REJECT;
      o.fin = FIN_ERROR;
    end
    return o;
  endfunction

  logic [7:0] b;
  logic       is_lf;
  logic       is_cr;
  logic       is_ctrl;
  line_t      line_took;
  line_t      line_s1;
  cls_out_t   cls_lf;
  cls_out_t   cls_last;
  logic       lf_res;
  logic       last_res;
  logic       line_res;
  logic       hdr_s1;
  fin_t       fin_s1;
  logic       hdr_s2;
  fin_t       fin_s2;
  logic       bad;
  res_t       line_r;
  res_t       final_r;

  assign b       = item.data_byte;
  assign is_lf   = (b == CH_LF);
  assign is_cr   = (b == CH_CR);
  assign is_ctrl = (b < CH_SPACE) || (b == CH_DEL);

  always_comb begin
    line_took = line_q;
    if (line_q.len < 3'd3) begin
      line_took.match_status = line_q.match_status && (b == status_char(line_q.len[1:0]));
    end else begin
      line_took.match_status = 1'b0;
    end
    if (line_q.len == 3'd0) begin
      line_took.first_dot   = (b == CH_DOT);
      line_took.first_blank = (b == CH_SPACE) || (b == CH_TAB);
    end
    if (!line_q.colon_found) begin
      if (b == CH_COLON) begin
        line_took.colon_found = 1'b1;
        if (line_q.len == 3'd0) begin
          line_took.name_invalid = 1'b1;
        end
      end else if (is_ctrl) begin
        line_took.name_invalid = 1'b1;
      end
    end
    if (line_q.len < LEN_MAX) begin
      line_took.len = line_q.len + 3'd1;
    end
  end

  always_comb begin
    if (is_lf) begin
      line_s1 = LINE_CLEAR;
    end else if (is_cr) begin
      line_s1 = line_q;
    end else begin
      line_s1 = line_took;
    end
  end

  // Line feed ends the line held before this byte.
  assign cls_lf = classify(line_q, header_q, fin_q);
  assign lf_res = is_lf && (fin_q == FIN_RUNNING);
  assign hdr_s1 = lf_res ? cls_lf.hdr : header_q;
  assign fin_s1 = lf_res ? cls_lf.fin : fin_q;

  // End of text closes an unterminated final line.
  assign cls_last = classify(line_s1, hdr_s1, fin_s1);
  assign last_res = item.end_of_text && (line_s1.len != 3'd0) && (fin_s1 == FIN_RUNNING);
  assign hdr_s2   = last_res ? cls_last.hdr : hdr_s1;
  assign fin_s2   = last_res ? cls_last.fin : fin_s1;

  assign bad = ((fin_s2 != FIN_RUNNING) && (fin_s2 != FIN_TERMINATED)) || !hdr_s2;

  assign line_res = lf_res || last_res;
  assign line_r   = '{line_class: (lf_res ? cls_lf.cls : cls_last.cls),
                      block_end: 1'b0, block_status: 1'b0};
  assign final_r  = '{line_class: CLS_NONE, block_end: 1'b1, block_status: bad};

  always_comb begin
    step.res0   = line_res ? line_r : final_r;
    step.res1   = final_r;
    step.push_n = {1'b0, line_res} + {1'b0, item.end_of_text};
    if (item.end_of_text) begin
      step.line_nxt   = LINE_CLEAR;
      step.header_nxt = 1'b0;
      step.fin_nxt    = FIN_RUNNING;
    end else begin
      step.line_nxt   = line_s1;
      step.header_nxt = hdr_s1;
      step.fin_nxt    = fin_s1;
    end
  end

endmodule

// File: src/mhbv_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`timescale 1ns / 1ps

module mhbv_result_fifo #(
  parameter int DEPTH = mhbv_pkg::MHBV_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_n,
  input  mhbv_pkg::res_t  push0,
  input  mhbv_pkg::res_t  push1,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_ready,
  output mhbv_pkg::res_t  out_data
);
  import mhbv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic          pop;

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room2     = (count_r <= ROOM_MAX);

  always_comb begin
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    count_nxt = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

// File: src/mail_header_block_validator.sv
// Top level of the mail header block validator.
`timescale 1ns / 1ps
// A line result or final result is written into the result queue at the byte transfer.
// Throughput: one byte per cycle while the queue has room for two results.
// A last byte that ends a line yields two results, drained one per cycle if out_ready.
// Reset: synchronous active-low rst_n clears line state, block state and the queue.
// After each block's final result the state returns to its reset values on its own.

module mail_header_block_validator #(
  parameter int QUEUE_DEPTH = mhbv_pkg::MHBV_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mhbv_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mhbv_pkg::res_t out_data
);
  import mhbv_pkg::*;

  // Per-line flags and per-block state, updated once per byte transfer.
  line_t line_r;
  logic  header_r;
  fin_t  fin_r;
  step_t step;
  logic  take;
  logic  room2;
  logic [1:0] push_n;

  // Accept a byte only while the queue can hold the two results it may cause.
  assign in_ready = room2;
  assign take     = in_valid && in_ready;
  assign push_n   = take ? step.push_n : 2'd0;

  // Classify the byte against the current line and block state.
  mhbv_line_unit u_line (
    .line_q   (line_r),
    .header_q (header_r),
    .fin_q    (fin_r),
    .item     (in_data),
    .step     (step)
  );

  // Advance state on each transfer; hold otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= LINE_CLEAR;
      header_r <= 1'b0;
      fin_r    <= FIN_RUNNING;
    end else if (take) begin
      line_r   <= step.line_nxt;
      header_r <= step.header_nxt;
      fin_r    <= step.fin_nxt;
    end
  end

  // Results wait here so a stalled consumer does not stop the byte stream at once.
  mhbv_result_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (step.res0),
    .push1     (step.res1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/mhbv_checker.sv
// Port-level assertions for the mail header block validator, bound to the top level.
`timescale 1ns / 1ps

module mhbv_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input mhbv_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input mhbv_pkg::res_t out_data
);
  import mhbv_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A final result always carries the none class.
  a_final_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_end |-> out_data.line_class == CLS_NONE)
    else $error("final result with a line class");

  // A line result has a real class and a clear status.
  a_line_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.block_end |->
      out_data.line_class != CLS_NONE && out_data.line_class != 3'd7 && !out_data.block_status)
    else $error("malformed line result");

  // The last byte of a block always leaves a result waiting.
  a_last_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.end_of_text |=> out_valid)
    else $error("no result after the last byte of a block");

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind mail_header_block_validator mhbv_checker u_mhbv_checker (.*);

// File: test/tb_mail_header_block_validator.sv
// Self-checking testbench for the mail header block validator: byte stream in, results out.
`timescale 1ns / 1ps

module tb_mail_header_block_validator;
  import mhbv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 410;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  // Shapes of generated text lines.
  typedef enum int {
    LN_HEADER, LN_CONT, LN_BLANK, LN_STATUS, LN_TERM, LN_BROKEN, LN_NOISE
  } line_kind_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  res_t out_data;

  mail_header_block_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Bytes waiting to be driven, and results waiting to be seen.
  in_t        pending_bytes[$];
  res_t       expected_results[$];
  logic [7:0] text_buf[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  int   queued_count;
  int   mismatch_count;
  int   cycle_count;
  logic in_taken;

  // Predicted validator state: current line, then the whole block.
  logic [2:0] cur_len;
  logic       cur_status_prefix;
  logic       cur_lead_dot;
  logic       cur_lead_blank;
  logic       cur_colon;
  logic       cur_name_bad;
  logic       blk_header_seen;
  fin_t       blk_fin;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line classifier prediction
  // ---------------------------------------------------------------------------

  task automatic clear_line();
    cur_len           = 3'd0;
    cur_status_prefix = 1'b1;
    cur_lead_dot      = 1'b0;
    cur_lead_blank    = 1'b0;
    cur_colon         = 1'b0;
    cur_name_bad      = 1'b0;
  endtask

  task automatic reset_block();
    clear_line();
    blk_header_seen = 1'b0;
    blk_fin         = FIN_RUNNING;
  endtask

  // Classify the line just ended; advance the block state as a side effect.
  function automatic logic [2:0] classify_line();
    logic [2:0] cls;
    if (cur_status_prefix && cur_len == 3'd3 && !blk_header_seen) begin
      cls = CLS_STATUS;
    end else if (cur_lead_dot && cur_len == 3'd1) begin
      blk_fin = FIN_TERMINATED;
      cls     = CLS_TERM;
    end else if (cur_len == 3'd0) begin
      cls = CLS_BLANK;
    end else if (cur_lead_blank) begin
      if (!blk_header_seen) begin
        blk_fin = FIN_ERROR;
        cls     = CLS_REJECT;
      end else begin
        cls = CLS_CONT;
      end
    end else if (cur_colon && !cur_name_bad) begin
      blk_header_seen = 1'b1;
      cls             = CLS_HEADER;
    end else begin
      blk_fin = FIN_ERROR;
      cls     = CLS_REJECT;
    end
    return cls;
  endfunction

  // Fold one accepted byte into the predicted state and queue its results.
  task automatic predict_transfer(input in_t item);
    logic [7:0] b;
    logic [7:0] prefix_ch;
    res_t       r;
    b = item.data_byte;
    if (b == CH_LF) begin
      if (blk_fin == FIN_RUNNING) begin
        r = '{line_class: classify_line(), block_end: 1'b0, block_status: 1'b0};
        expected_results.insert(expected_results.size(), r);
      end
      clear_line();
    end else if (b != CH_CR) begin
      case (cur_len)
        3'd0:    prefix_ch = CH_PLUS;
        3'd1:    prefix_ch = CH_O;
        default: prefix_ch = CH_K;
      endcase
      cur_status_prefix = (cur_len < 3'd3) ? (cur_status_prefix && b == prefix_ch) : 1'b0;
      if (cur_len == 3'd0) begin
        cur_lead_dot   = (b == CH_DOT);
        cur_lead_blank = (b == CH_SPACE || b == CH_TAB);
      end
      if (!cur_colon) begin
        if (b == CH_COLON) begin
          cur_colon = 1'b1;
          if (cur_len == 3'd0) cur_name_bad = 1'b1;
        end else if (b < 8'd32 || b == CH_DEL) begin
          cur_name_bad = 1'b1;
        end
      end
      if (cur_len < LEN_MAX) cur_len = cur_len + 3'd1;
    end

    if (item.end_of_text) begin
      // Classify an unterminated last line, then report the block verdict.
      if (cur_len != 3'd0 && blk_fin == FIN_RUNNING) begin
        r = '{line_class: classify_line(), block_end: 1'b0, block_status: 1'b0};
        expected_results.insert(expected_results.size(), r);
      end
      r.line_class   = CLS_NONE;
      r.block_end    = 1'b1;
      r.block_status = (blk_fin != FIN_RUNNING && blk_fin != FIN_TERMINATED) ||
                       !blk_header_seen;
      expected_results.insert(expected_results.size(), r);
      reset_block();
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= REPORT_MAX)
        $display("[%0t] unexpected result: class %0d end %0b status %0b", $realtime,
                 got.line_class, got.block_end, got.block_status);
    end else begin
      want = expected_results.pop_front();
      if (got.line_class !== want.line_class || got.block_end !== want.block_end ||
          got.block_status !== want.block_status) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_MAX)
          $display("[%0t] mismatch: want cls %0d end %0b st %0b, got cls %0d end %0b st %0b",
                   $realtime, want.line_class, want.block_end, want.block_status,
                   got.line_class, got.block_end, got.block_status);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  // Append one byte to the text under construction.
  task automatic add_byte(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Header name byte: printable, never a colon.
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if (c == CH_COLON) c = 8'h2D;
    return c;
  endfunction

  // Value byte: mostly printable, sometimes any byte but a line feed.
  function automatic logic [7:0] value_char();
    logic [7:0] c;
    if ($urandom_range(9) != 0) begin
      c = 8'($urandom_range(32, 126));
    end else begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_LF) c = 8'h76;
    end
    return c;
  endfunction

  // Append one line; close it with LF or CR LF unless this is an open last line.
  task automatic add_line(input line_kind_t kind, input bit close);
    logic [7:0] c;
    case (kind)
      LN_HEADER: begin
        repeat ($urandom_range(1, 6)) add_byte(name_char());
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 12)) add_byte(value_char());
      end
      LN_CONT: begin
        add_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
        repeat ($urandom_range(0, 8)) add_byte(value_char());
      end
      LN_BLANK: begin
        if (!close) add_byte(CH_CR);
      end
      LN_STATUS: begin
        case ($urandom_range(3))
          0, 1:    put_str("+OK");
          2:       put_str("+O");
          default: put_str("+OKx");
        endcase
      end
      LN_TERM: begin
        case ($urandom_range(3))
          0, 1:    put_str(".");
          2:       put_str("..");
          default: put_str(". ");
        endcase
      end
      LN_BROKEN: begin
        case ($urandom_range(2))
          0: repeat ($urandom_range(1, 9)) add_byte(name_char());
          1: begin
            add_byte(CH_COLON);
            repeat ($urandom_range(0, 5)) add_byte(value_char());
          end
          default: begin
            // Control byte inside the name, before the colon.
            repeat ($urandom_range(0, 4)) add_byte(name_char());
            c = 8'($urandom_range(0, 32));
            if (c == 8'd32) c = CH_DEL;
            if (c == CH_LF) c = 8'h00;
            add_byte(c);
            repeat ($urandom_range(0, 3)) add_byte(name_char());
            add_byte(CH_COLON);
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(0, 255)));
      end
    endcase
    if (close) begin
      if ($urandom_range(3) == 0) add_byte(CH_CR);
      add_byte(CH_LF);
    end
  endtask

  // Move the built text to the send queue, flagging its last byte as end of text.
  task automatic send_block();
    in_t item;
    if (text_buf.size() == 0) add_byte(8'($urandom_range(0, 255)));
    foreach (text_buf[i]) begin
      item.data_byte   = text_buf[i];
      item.end_of_text = (i == text_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
    end
    queued_count = queued_count + text_buf.size();
    text_buf.delete();
  endtask

  task automatic build_block();
    if ($urandom_range(99) < 70) begin
      // Well-formed block with random content.
      if ($urandom_range(1)) add_line(LN_STATUS, 1'b1);
      repeat ($urandom_range(1, 5)) begin
        add_line(LN_HEADER, 1'b1);
        repeat ($urandom_range(0, 2)) add_line(LN_CONT, 1'b1);
        if ($urandom_range(9) == 0) add_line(LN_BLANK, 1'b1);
      end
      case ($urandom_range(3))
        0: add_line(LN_TERM, 1'b1);
        1: begin
          // Trailing lines after the terminator are ignored.
          add_line(LN_TERM, 1'b1);
          add_line(line_kind_t'($urandom_range(0, 6)), $urandom_range(1));
        end
        2: ;
        default: add_line(LN_HEADER, 1'b0);
      endcase
    end else begin
      repeat ($urandom_range(1, 6))
        add_line(line_kind_t'($urandom_range(0, 6)), $urandom_range(3) != 0);
    end
    send_block();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // Offer the next byte, or idle for this cycle.
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_transfer(in_data);
        pending_bytes.delete(0);
      end
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin
    int start_count;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queued_count   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    reset_block();

    // Directed: status, header with top-bit byte, continuation, blank, terminator,
    // then a line after the end that must give no line result.
    put_str("+OK");
    add_byte(CH_LF);
    put_str("A:");
    add_byte(8'hFF);
    add_byte(CH_LF);
    add_byte(CH_TAB);
    put_str("c");
    add_byte(CH_LF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    put_str(".");
    add_byte(CH_LF);
    put_str("z");
    send_block();
    // Colon at the start of an open last line.
    put_str(":x");
    send_block();
    // Zero byte alone: a control byte, so rejected.
    add_byte(8'h00);
    send_block();
    // Continuation before any header, text ending on the line feed.
    add_byte(CH_SPACE);
    add_byte(CH_LF);
    send_block();
    // Empty final line: only a dropped carriage return.
    add_byte(CH_CR);
    send_block();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      start_count = queued_count;
      while (queued_count - start_count < PHASE_ITEMS) build_block();
      // Hold the sender until every transfer is in and every result is out.
      while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    end

    // Catch any stray result after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: mail_header_block_validator.f
src/mhbv_pkg.sv
src/mhbv_line_unit.sv
src/mhbv_result_fifo.sv
src/mail_header_block_validator.sv
src/mhbv_checker.sv
test/tb_mail_header_block_validator.sv
